>>> sv/mal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mal_pkg: shared types and codes for the masked address allow list
// Command and family codes, transfer payload structs and the token that
// walks the rule cell chain.
// ----------------------------------------------------------------------------
package mal_pkg;

   localparam logic [1:0] CMD_CHECK  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [1:0] FAM_IPV4  = 2'd0;
   localparam logic [1:0] FAM_IPV6  = 2'd1;
   localparam logic [1:0] FAM_LOCAL = 2'd2;
   localparam logic [1:0] FAM_OTHER = 2'd3;

   // IPv4 clients map to ::ffff:a.b.c.d
   localparam logic [31:0] MAP_V4_PREFIX = 32'h0000ffff;
   localparam logic [63:0] MAP_V4_HIGH   = 64'h0;

   localparam int unsigned COUNT_W = 5;

   typedef struct packed {
      logic [1:0]  command;
      logic [1:0]  family;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [63:0] mask_high;
      logic [63:0] mask_low;
   } req_type;

   typedef struct packed {
      logic               allowed;
      logic               inserted;
      logic               duplicate;
      logic               table_full;
      logic [COUNT_W-1:0] rule_count;
   } rsp_type;

   // hit: check matched, or insert found a duplicate
   typedef struct packed {
      logic        active;
      logic        is_check;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [63:0] mask_high;
      logic [63:0] mask_low;
      logic        hit;
      logic        stored;
   } token_type;

endpackage
`default_nettype wire

>>> sv/mal_rule_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mal_rule_cell: one allow rule of the chain
// Holds an address, a mask and a valid bit. Compares the passing token,
// stores an insert at the first free cell, and forwards the token.
// ----------------------------------------------------------------------------
module mal_rule_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               clear_all,
   input  wire mal_pkg::token_type token_in,
   output      mal_pkg::token_type token_out,
   output      logic               rule_valid
);

   logic               valid_ff;
   logic [63:0]        addr_high_ff;
   logic [63:0]        addr_low_ff;
   logic [63:0]        mask_high_ff;
   logic [63:0]        mask_low_ff;
   mal_pkg::token_type token_ff;
   mal_pkg::token_type token_in_next;
   logic               masked_match;
   logic               exact_match;
   logic               store;

   always_comb begin
      masked_match = ((addr_high_ff & mask_high_ff) == (token_in.addr_high & mask_high_ff))
                  && ((addr_low_ff & mask_low_ff) == (token_in.addr_low & mask_low_ff));
      exact_match  = (addr_high_ff == token_in.addr_high)
                  && (addr_low_ff == token_in.addr_low)
                  && (mask_high_ff == token_in.mask_high)
                  && (mask_low_ff == token_in.mask_low);
      // held rules form a prefix, so every held rule was checked before the first free cell
      store = token_in.active && !token_in.is_check && !valid_ff
           && !token_in.hit && !token_in.stored;
      token_in_next = token_in;
      if (token_in.is_check) begin
         token_in_next.hit = token_in.hit || (valid_ff && masked_match);
      end else begin
         token_in_next.hit = token_in.hit || (valid_ff && exact_match);
      end
      token_in_next.stored = token_in.stored || store;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
         if (clear_all) begin
            valid_ff <= 1'b0;
         end else if (store) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         addr_high_ff <= token_in.addr_high;
         addr_low_ff  <= token_in.addr_low;
         mask_high_ff <= token_in.mask_high;
         mask_low_ff  <= token_in.mask_low;
      end
   end

   assign token_out  = token_ff;
   assign rule_valid = valid_ff;

endmodule
`default_nettype wire

>>> sv/masked_address_allow_list_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masked_address_allow_list_unit: masked address allow list, top level
// Client admission checks and rule inserts walk a chain of rule cells.
//
//   channel   ports                      transfer when
//   request   start, busy, req_payload   start && !busy
//   result    rsp_strobe, rsp_payload    rsp_strobe (one cycle, no stall)
//
// A check or insert of an IPv4/IPv6 item walks the chain one cell a cycle:
// the result strobes once the token leaves the tail cell, busy held meanwhile.
// A check of an empty table or of a local/other family, a clear, an insert
// of a local/other family and the unused command answer in the cycle after the transfer.
// Synchronous reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module masked_address_allow_list_unit #(
   parameter int unsigned ENTRIES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire mal_pkg::req_type req_payload,
   output      logic             rsp_strobe,
   output      mal_pkg::rsp_type rsp_payload
);

   localparam int unsigned CW = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               rsp_strobe_ff;
   mal_pkg::rsp_type   rsp_ff;
   mal_pkg::rsp_type   fast_rsp;
   mal_pkg::rsp_type   tail_rsp;
   mal_pkg::token_type chain [ENTRIES+1];
   logic [ENTRIES-1:0] valid_vec;
   logic               accept;
   logic               is_ip;
   logic               slow;
   logic               clear_all;
   logic [63:0]        map_high;
   logic [63:0]        map_low;
   logic [CW+4:0]      count_ext;
   logic [CW+4:0]      count_in_ext;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign clear_all = accept && (req_payload.command == mal_pkg::CMD_CLEAR);

   always_comb begin
      is_ip = req_payload.family inside {mal_pkg::FAM_IPV4, mal_pkg::FAM_IPV6};
      if (req_payload.family == mal_pkg::FAM_IPV4) begin
         map_high = mal_pkg::MAP_V4_HIGH;
         map_low  = {mal_pkg::MAP_V4_PREFIX, req_payload.addr_low[31:0]};
      end else begin
         map_high = req_payload.addr_high;
         map_low  = req_payload.addr_low;
      end
      slow = is_ip && ((req_payload.command == mal_pkg::CMD_INSERT)
          || ((req_payload.command == mal_pkg::CMD_CHECK) && (count_ff != '0)));
   end

   // inject a token into the head cell
   always_comb begin
      chain[0].active    = accept && slow;
      chain[0].is_check  = (req_payload.command == mal_pkg::CMD_CHECK);
      chain[0].addr_high = map_high;
      chain[0].addr_low  = map_low;
      chain[0].mask_high = req_payload.mask_high;
      chain[0].mask_low  = req_payload.mask_low;
      chain[0].hit       = 1'b0;
      chain[0].stored    = 1'b0;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      mal_rule_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear_all  (clear_all),
         .token_in   (chain[i]),
         .token_out  (chain[i+1]),
         .rule_valid (valid_vec[i])
      );
   end

   always_comb begin
      count_ext             = {5'b0, count_ff};
      fast_rsp.allowed      = (req_payload.command == mal_pkg::CMD_CHECK)
                           && ((req_payload.family == mal_pkg::FAM_LOCAL)
                           || (is_ip && (count_ff == '0)));
      fast_rsp.inserted     = 1'b0;
      fast_rsp.duplicate    = 1'b0;
      fast_rsp.table_full   = 1'b0;
      fast_rsp.rule_count   = clear_all ? '0 : count_ext[4:0];

      count_in              = count_ff + CW'(chain[ENTRIES].stored);
      count_in_ext          = {5'b0, count_in};
      tail_rsp.allowed      = chain[ENTRIES].is_check && chain[ENTRIES].hit;
      tail_rsp.inserted     = !chain[ENTRIES].is_check && chain[ENTRIES].stored;
      tail_rsp.duplicate    = !chain[ENTRIES].is_check && chain[ENTRIES].hit;
      tail_rsp.table_full   = !chain[ENTRIES].is_check && !chain[ENTRIES].hit
                           && !chain[ENTRIES].stored;
      tail_rsp.rule_count   = count_in_ext[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (slow) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     rsp_strobe_ff <= 1'b1;
                     if (clear_all) begin
                        count_ff <= '0;
                     end
                  end
               end
            end
            ST_SCAN: begin
               // hold until the token leaves the tail cell
               if (chain[ENTRIES].active) begin
                  rsp_strobe_ff <= 1'b1;
                  count_ff      <= count_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !slow) begin
         rsp_ff <= fast_rsp;
      end else if (chain[ENTRIES].active) begin
         rsp_ff <= tail_rsp;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while a scan is in flight");

   a_insert_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot0({rsp_payload.inserted, rsp_payload.duplicate,
                               rsp_payload.table_full}))
      else $error("more than one insert outcome flagged");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ENTRIES)
      else $error("rule count exceeds table size");

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[ENTRIES].active |-> (state_ff == ST_SCAN))
      else $error("token left the chain outside a scan");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_vec) == count_ff))
      else $error("rule count disagrees with held cells");
`endif

endmodule
`default_nettype wire

>>> sim/tb_masked_address_allow_list_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_masked_address_allow_list_unit: self-checking bench for the allow list
// A table of directed items runs first: empty-table checks, families that
// are ignored or denied, IPv4 mapping, duplicates and clears. Random
// episodes follow: insert bursts that fill the table up to the full case,
// then checks aimed near the held rules. Each result is compared with the
// shadow rule table's outcome, or with a directed row's typed expectation.
// ----------------------------------------------------------------------------
module tb_masked_address_allow_list_unit;

   localparam int unsigned ENTRIES      = 16;
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;
   localparam int          RANDOM_ITEMS = 850;

   typedef struct {
      mal_pkg::req_type item;
      bit               typed;
      mal_pkg::rsp_type want;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   mal_pkg::req_type req_payload;
   logic             rsp_strobe;
   mal_pkg::rsp_type rsp_payload;

   // shadow of the rule table, in mapped 128-bit form
   logic [127:0] held_addr [ENTRIES];
   logic [127:0] held_mask [ENTRIES];
   bit           held_valid [ENTRIES];
   int unsigned  held_total;

   mal_pkg::rsp_type pending_outcomes[$];
   dir_row_type      dir_rows[$];
   int               errors;
   int               effective_items;
   int               transfer_count;

   masked_address_allow_list_unit #(
      .ENTRIES(ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [127:0] prefix_mask(input int unsigned len);
      return {128{1'b1}} << (128 - len);
   endfunction

   function automatic mal_pkg::req_type make_req(input logic [1:0] cmd,
                                                 input logic [1:0] fam,
                                                 input logic [63:0] ah, input logic [63:0] al,
                                                 input logic [63:0] mh, input logic [63:0] ml);
      mal_pkg::req_type r;
      r.command   = cmd;
      r.family    = fam;
      r.addr_high = ah;
      r.addr_low  = al;
      r.mask_high = mh;
      r.mask_low  = ml;
      return r;
   endfunction

   function automatic mal_pkg::rsp_type make_rsp(input bit a, input bit i, input bit d,
                                                 input bit f, input int unsigned n);
      mal_pkg::rsp_type o;
      o.allowed    = a;
      o.inserted   = i;
      o.duplicate  = d;
      o.table_full = f;
      o.rule_count = n[mal_pkg::COUNT_W-1:0];
      return o;
   endfunction

   // Apply one item to the shadow table and return the outcome it causes.
   function automatic mal_pkg::rsp_type allow_list_outcome(input mal_pkg::req_type r);
      logic [127:0]     client;
      logic [127:0]     rule_mask;
      mal_pkg::rsp_type o;
      int               slot;
      o = '0;
      slot = -1;
      if (r.family == mal_pkg::FAM_IPV4)
         client = {mal_pkg::MAP_V4_HIGH, mal_pkg::MAP_V4_PREFIX, r.addr_low[31:0]};
      else
         client = {r.addr_high, r.addr_low};
      rule_mask = {r.mask_high, r.mask_low};
      case (r.command)
         mal_pkg::CMD_CHECK: begin
            if (r.family == mal_pkg::FAM_LOCAL) begin
               o.allowed = 1'b1;
            end else if (r.family == mal_pkg::FAM_IPV4 || r.family == mal_pkg::FAM_IPV6) begin
               if (held_total == 0)
                  o.allowed = 1'b1;
               for (int i = 0; i < ENTRIES; i++)
                  if (held_valid[i] && (held_addr[i] & held_mask[i]) == (client & held_mask[i]))
                     o.allowed = 1'b1;
            end
         end
         mal_pkg::CMD_INSERT: begin
            if (r.family == mal_pkg::FAM_IPV4 || r.family == mal_pkg::FAM_IPV6) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (held_valid[i] && held_addr[i] == client && held_mask[i] == rule_mask)
                     o.duplicate = 1'b1;
               if (!o.duplicate) begin
                  for (int i = ENTRIES - 1; i >= 0; i--)
                     if (!held_valid[i])
                        slot = i;
                  if (slot >= 0) begin
                     held_addr[slot]  = client;
                     held_mask[slot]  = rule_mask;
                     held_valid[slot] = 1'b1;
                     held_total++;
                     o.inserted = 1'b1;
                  end else begin
                     o.table_full = 1'b1;
                  end
               end
            end
         end
         mal_pkg::CMD_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++)
               held_valid[i] = 1'b0;
            held_total = 0;
         end
         default: ;
      endcase
      o.rule_count = held_total[mal_pkg::COUNT_W-1:0];
      return o;
   endfunction

   task automatic note_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   task automatic add_row(input mal_pkg::req_type r, input bit typed,
                          input mal_pkg::rsp_type want);
      dir_rows.push_back('{r, typed, want});
   endtask

   // Pace the sender, then hold the item until the block takes it.
   task automatic send_item(input mal_pkg::req_type r, input bit typed,
                            input mal_pkg::rsp_type want);
      int               gap;
      mal_pkg::rsp_type predicted;
      transfer_count++;
      if (transfer_count == 200) begin
         // drain: nothing in flight before the next transfer
         @(negedge clock);
         start <= 1'b0;
         while (pending_outcomes.size() != 0)
            @(posedge clock);
      end else if (!(transfer_count > 350 && transfer_count <= 520) &&
                   $urandom_range(99) < 32) begin
         gap = $urandom_range(1, ENTRIES + 3);
         repeat (gap) begin
            @(negedge clock);
            start       <= 1'b0;
            req_payload <= make_req(2'($urandom_range(3)), 2'($urandom_range(3)),
                                    rnd64(), rnd64(), rnd64(), rnd64());
         end
      end
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      predicted = allow_list_outcome(r);
      pending_outcomes.push_back(typed ? want : predicted);
      if (!(r.command == CMD_UNUSED ||
            (r.command == mal_pkg::CMD_INSERT &&
             (r.family == mal_pkg::FAM_LOCAL || r.family == mal_pkg::FAM_OTHER))))
         effective_items++;
   endtask

   // One random episode: an insert burst, a run of checks, maybe a clear.
   task automatic run_episode();
      int               pick;
      int unsigned      len;
      logic [127:0]     a;
      logic [127:0]     m;
      logic [127:0]     client;
      logic [1:0]       fam;
      bit               v4;
      mal_pkg::req_type r;
      repeat ($urandom_range(1, 20)) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            r = make_req(mal_pkg::CMD_INSERT,
                         $urandom_range(1) ? mal_pkg::FAM_LOCAL : mal_pkg::FAM_OTHER,
                         rnd64(), rnd64(), rnd64(), rnd64());
            if ($urandom_range(1))
               r.command = CMD_UNUSED;
            if ($urandom_range(1))
               r.family = 2'($urandom_range(3));
         end else if (pick < 30 && held_total != 0) begin
            // resend a held rule: must come back as a duplicate
            pick = $urandom_range(held_total - 1);
            a = held_addr[pick];
            m = held_mask[pick];
            if (a[127:32] == {mal_pkg::MAP_V4_HIGH, mal_pkg::MAP_V4_PREFIX} &&
                $urandom_range(1))
               r = make_req(mal_pkg::CMD_INSERT, mal_pkg::FAM_IPV4, rnd64(),
                            {$urandom, a[31:0]}, m[127:64], m[63:0]);
            else
               r = make_req(mal_pkg::CMD_INSERT, mal_pkg::FAM_IPV6, a[127:64], a[63:0],
                            m[127:64], m[63:0]);
         end else begin
            v4 = 1'($urandom_range(1));
            len = v4 ? 96 + $urandom_range(32) : $urandom_range(128);
            case ($urandom_range(5))
               0:       m = {128{1'b1}};
               1:       m = '0;
               2:       m = {rnd64(), rnd64()};
               default: m = prefix_mask(len);
            endcase
            a = {rnd64(), rnd64()};
            r = make_req(mal_pkg::CMD_INSERT, v4 ? mal_pkg::FAM_IPV4 : mal_pkg::FAM_IPV6,
                         a[127:64], a[63:0], m[127:64], m[63:0]);
         end
         send_item(r, 1'b0, '0);
      end
      repeat ($urandom_range(4, 16)) begin
         pick = $urandom_range(99);
         if (pick < 55 && held_total != 0) begin
            // client that agrees with a held rule under its mask, at times with one bit flipped
            pick = $urandom_range(held_total - 1);
            m = held_mask[pick];
            client = (held_addr[pick] & m) | ({rnd64(), rnd64()} & ~m);
            if ($urandom_range(3) == 0)
               client[7'($urandom_range(127))] ^= 1'b1;
            if (client[127:32] == {mal_pkg::MAP_V4_HIGH, mal_pkg::MAP_V4_PREFIX} &&
                $urandom_range(1))
               r = make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV4, rnd64(),
                            {$urandom, client[31:0]}, rnd64(), rnd64());
            else
               r = make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV6, client[127:64],
                            client[63:0], rnd64(), rnd64());
         end else begin
            if (pick < 80)
               fam = $urandom_range(1) ? mal_pkg::FAM_IPV4 : mal_pkg::FAM_IPV6;
            else if (pick < 90)
               fam = mal_pkg::FAM_LOCAL;
            else
               fam = mal_pkg::FAM_OTHER;
            r = make_req(mal_pkg::CMD_CHECK, fam, rnd64(), rnd64(), rnd64(), rnd64());
         end
         send_item(r, 1'b0, '0);
      end
      if ($urandom_range(99) < 40)
         send_item(make_req(mal_pkg::CMD_CLEAR, 2'($urandom_range(3)), rnd64(), rnd64(),
                            rnd64(), rnd64()), 1'b0, '0);
   endtask

   always @(posedge clock) begin : watch_results
      mal_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            note_mismatch("result with no expectation waiting");
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("allowed", 8'(rsp_payload.allowed), 8'(want.allowed));
            compare_field("inserted", 8'(rsp_payload.inserted), 8'(want.inserted));
            compare_field("duplicate", 8'(rsp_payload.duplicate), 8'(want.duplicate));
            compare_field("table_full", 8'(rsp_payload.table_full), 8'(want.table_full));
            compare_field("rule_count", 8'(rsp_payload.rule_count), 8'(want.rule_count));
         end
      end
   end

   initial begin
      localparam logic [63:0] ONES = {64{1'b1}};
      reset           = 1'b1;
      start           = 1'b0;
      req_payload     = '0;
      errors          = 0;
      effective_items = 0;
      transfer_count  = 0;
      held_total      = 0;
      for (int i = 0; i < ENTRIES; i++)
         held_valid[i] = 1'b0;

      // empty table, ignored families and the unused command
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV4, 64'h0, 64'h0a010203,
                       64'h0, 64'h0), 1, make_rsp(1, 0, 0, 0, 0));
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_OTHER, ONES, ONES, ONES, ONES), 1,
              make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_LOCAL, 64'h0, 64'h0, 64'h0, 64'h0), 1,
              make_rsp(1, 0, 0, 0, 0));
      add_row(make_req(CMD_UNUSED, mal_pkg::FAM_IPV6, ONES, ONES, ONES, ONES), 1,
              make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(mal_pkg::CMD_INSERT, mal_pkg::FAM_LOCAL, ONES, ONES, ONES, ONES), 1,
              make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(mal_pkg::CMD_INSERT, mal_pkg::FAM_OTHER, 64'h0, 64'h0, ONES, ONES), 1,
              make_rsp(0, 0, 0, 0, 0));
      // IPv4 rule 10.1.2.0/24; upper addr_low bits must not matter
      add_row(make_req(mal_pkg::CMD_INSERT, mal_pkg::FAM_IPV4, 64'h0, 64'h0a010203, ONES,
                       64'hffffffff_ffffff00), 1, make_rsp(0, 1, 0, 0, 1));
      add_row(make_req(mal_pkg::CMD_INSERT, mal_pkg::FAM_IPV4, ONES, 64'hdeadbeef_0a010203,
                       ONES, 64'hffffffff_ffffff00), 1, make_rsp(0, 0, 1, 0, 1));
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV4, 64'h0, 64'h0a0102fe,
                       64'h0, 64'h0), 0, '0);
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV4, 64'h0, 64'h0b010203,
                       ONES, ONES), 0, '0);
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV6, 64'h0, 64'h0000ffff_0a010280,
                       64'h0, 64'h0), 0, '0);
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_LOCAL, ONES, ONES, 64'h0, 64'h0), 1,
              make_rsp(1, 0, 0, 0, 1));
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_OTHER, 64'h0, 64'h0a010203,
                       64'h0, 64'h0), 1, make_rsp(0, 0, 0, 0, 1));
      // same address, different mask: a new rule, not a duplicate
      add_row(make_req(mal_pkg::CMD_INSERT, mal_pkg::FAM_IPV6, ONES, ONES, ONES, ONES), 1,
              make_rsp(0, 1, 0, 0, 2));
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV6, ONES, ONES, 64'h0, 64'h0),
              0, '0);
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV6, ONES, ONES - 1, 64'h0, 64'h0),
              0, '0);
      add_row(make_req(mal_pkg::CMD_INSERT, mal_pkg::FAM_IPV6, ONES, ONES, 64'h0, 64'h0), 1,
              make_rsp(0, 1, 0, 0, 3));
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV6, 64'h0, 64'h0, 64'h0, 64'h0),
              0, '0);
      add_row(make_req(mal_pkg::CMD_CLEAR, mal_pkg::FAM_IPV4, ONES, ONES, ONES, ONES), 1,
              make_rsp(0, 0, 0, 0, 0));
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV6, 64'h0, 64'h0, 64'h0, 64'h0), 1,
              make_rsp(1, 0, 0, 0, 0));
      add_row(make_req(mal_pkg::CMD_INSERT, mal_pkg::FAM_IPV4, 64'h0, 64'hffffffff,
                       ONES, ONES), 1, make_rsp(0, 1, 0, 0, 1));
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV4, ONES, 64'h0, ONES, ONES),
              0, '0);
      add_row(make_req(mal_pkg::CMD_CHECK, mal_pkg::FAM_IPV4, 64'h0, ONES, 64'h0, 64'h0),
              0, '0);
      add_row(make_req(mal_pkg::CMD_CLEAR, mal_pkg::FAM_OTHER, 64'h0, 64'h0, 64'h0, 64'h0), 1,
              make_rsp(0, 0, 0, 0, 0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k])
         send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

      effective_items = 0;
      while (effective_items < RANDOM_ITEMS)
         run_episode();

      @(negedge clock);
      start <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (ENTRIES + 4) @(posedge clock);

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
sv/mal_pkg.sv
sv/mal_rule_cell.sv
sv/masked_address_allow_list_unit.sv
sim/tb_masked_address_allow_list_unit.sv
